/* src/lsu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsu_pkg
// Shared types and constants of the lottery scheduler unit.
// ----------------------------------------------------------------------------
package lsu_pkg;

   localparam int TICKET_W   = 16;   // ticket register width
   localparam int REG_COUNT  = 8;    // number of ticket registers
   localparam int CSR_IDX_W  = 4;    // register index width, room for out-of-range writes
   localparam int RAND_W     = 32;   // random word width
   localparam int GRANT_W    = 32;   // grant counter width
   localparam int WIN_W      = 3;    // reported winner index width
   localparam int SUM_W      = 19;   // holds REG_COUNT * (2**TICKET_W - 1)
   localparam int SLOT_EXT_W = 4;    // slot index widened to cover up to 16 slots
   localparam int DIV_CNT_W  = 5;    // counts the RAND_W division steps
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(RAND_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_SCAN,
      ST_UPDATE,
      ST_OUT
   } state_type;

endpackage

/* src/lottery_scheduler_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lottery_scheduler_unit
// Weighted lottery arbiter with per-process ticket registers and grant counters.
// ----------------------------------------------------------------------------
// One random word per transaction. The unit sums the ticket registers one slot
// per cycle, reduces the word modulo that total in a bit-serial remainder unit
// that takes one bit at a time, then sweeps the slots again one per cycle to find
// the first whose running ticket sum exceeds the remainder, and bumps that
// slot's saturating grant counter. The result is held until the output stream
// takes it; a zero ticket total skips the division and returns no_winner. One
// item is in flight at a time. Ticket writes at indices at or above 8 or
// PROCESS_SLOTS are dropped; slots 8 and 9 hold no tickets.
// ----------------------------------------------------------------------------
module lottery_scheduler_unit #(
   parameter int PROCESS_SLOTS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_we,
   input  logic [lsu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lsu_pkg::TICKET_W-1:0]      csr_wdata,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lsu_pkg::REQ_DATA_W-1:0]    req_tdata,   // [31:0] random_value
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lsu_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [2:0] winner, [34:3] winner_grants, [39:35] zero
   output logic                              rsp_tuser    // [0] no_winner
);
   import lsu_pkg::*;

   localparam int SLOT_W = $clog2(PROCESS_SLOTS);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(PROCESS_SLOTS - 1);

   state_type            state_ff, state_in;
   logic [TICKET_W-1:0]  tickets_ff [REG_COUNT];
   logic [GRANT_W-1:0]   grants_ff [PROCESS_SLOTS];
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [SUM_W-1:0]     acc_ff, acc_in;
   logic [RAND_W-1:0]    rand_ff, rand_in;
   logic [WIN_W-1:0]     winner_ff, winner_in;
   logic [GRANT_W-1:0]   count_ff, count_in;
   logic                 nowin_ff, nowin_in;
   logic                 grant_we;

   logic [SLOT_EXT_W-1:0] slot_ext;
   logic [TICKET_W-1:0]   slot_tickets;
   logic [SUM_W-1:0]      acc_sum;
   logic [GRANT_W-1:0]    grant_cur;
   logic                  div_start;
   logic                  div_done;
   logic [SUM_W-1:0]      draw;

   lsu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rand_ff),
      .divisor   (acc_sum),
      .done      (div_done),
      .remainder (draw)
   );

   // slots without a ticket register read as zero tickets
   always_comb begin
      slot_ext = SLOT_EXT_W'(slot_ff);
      if (32'(slot_ext) < REG_COUNT) begin
         slot_tickets = tickets_ff[slot_ext[WIN_W-1:0]];
      end else begin
         slot_tickets = '0;
      end
      acc_sum   = acc_ff + SUM_W'(slot_tickets);
      grant_cur = grants_ff[slot_ff];
   end

   always_comb begin
      state_in   = state_ff;
      slot_in    = slot_ff;
      acc_in     = acc_ff;
      rand_in    = rand_ff;
      winner_in  = winner_ff;
      count_in   = count_ff;
      nowin_in   = nowin_ff;
      grant_we   = 1'b0;
      div_start  = 1'b0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               rand_in  = req_tdata[RAND_W-1:0];
               acc_in   = '0;
               slot_in  = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            acc_in  = acc_sum;
            slot_in = slot_ff + 1'b1;
            if (slot_ff == SLOT_LAST) begin
               slot_in = '0;
               if (acc_sum == '0) begin
                  winner_in = '0;
                  count_in  = '0;
                  nowin_in  = 1'b1;
                  state_in  = ST_OUT;
               end else begin
                  // acc_sum is the full total here
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               acc_in   = '0;
               slot_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            acc_in = acc_sum;
            if (draw < acc_sum) begin
               state_in = ST_UPDATE;
            end else if (slot_ff == SLOT_LAST) begin
               // unreachable with a nonzero total
               winner_in = '0;
               count_in  = '0;
               nowin_in  = 1'b1;
               state_in  = ST_OUT;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            grant_we  = 1'b1;
            winner_in = slot_ext[WIN_W-1:0];
            nowin_in  = 1'b0;
            if (&grant_cur) begin
               count_in = grant_cur;
            end else begin
               count_in = grant_cur + 1'b1;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int k = 0; k < REG_COUNT; k++) begin
            tickets_ff[k] <= TICKET_W'(1);
         end
         for (int k = 0; k < PROCESS_SLOTS; k++) begin
            grants_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we && (32'(csr_index) < REG_COUNT) && (32'(csr_index) < PROCESS_SLOTS)) begin
            tickets_ff[csr_index[WIN_W-1:0]] <= csr_wdata;
         end
         if (grant_we) begin
            grants_ff[slot_ff] <= count_in;
         end
      end
      slot_ff   <= slot_in;
      acc_ff    <= acc_in;
      rand_ff   <= rand_in;
      winner_ff <= winner_in;
      count_ff  <= count_in;
      nowin_ff  <= nowin_in;
   end

   assign rsp_tdata = {(RSP_DATA_W - GRANT_W - WIN_W)'(0), count_ff, winner_ff};
   assign rsp_tuser = nowin_ff;

endmodule

/* src/lsu_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsu_div
// Bit-serial restoring remainder: one dividend bit per cycle, RAND_W steps.
// ----------------------------------------------------------------------------
module lsu_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lsu_pkg::RAND_W-1:0]    dividend,
   input  logic [lsu_pkg::SUM_W-1:0]     divisor,
   output logic                          done,
   output logic [lsu_pkg::SUM_W-1:0]    remainder
);
   import lsu_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RAND_W-1:0]    dvd_ff, dvd_in;
   logic [SUM_W-1:0]     dvs_ff, dvs_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [SUM_W:0]       trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      // shift the next dividend bit into the partial remainder
      trial   = {rem_ff, dvd_ff[RAND_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[RAND_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = SUM_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[SUM_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
